FILE: design/epce_pkg.sv
// package: widths, breakpoint tables, curve codes and pipeline sideband type
`default_nettype none

package epce_pkg;

  localparam int NOISE_W = 16;
  localparam int SEL_W = 2;
  localparam int VALUE_W = 17;
  localparam int T_W = 16;
  localparam int S_W = 17;

  localparam int ROM_LIMIT = 16;
  localparam int ROM_CURVES = 4;
  localparam int ROM_IDX_W = 4;
  localparam int COUNT_W = 5;

  localparam int MAX_POINTS_DEF = 16;
  localparam int NUM_CURVES_DEF = 3;

  localparam int DIV_STAGES = 8;
  localparam int DIV_STEP = 2;

  localparam logic [SEL_W-1:0] CURVE_SMOOTHER = 2'd0;
  localparam logic [SEL_W-1:0] CURVE_SMOOTH = 2'd1;
  localparam logic [SEL_W-1:0] CURVE_LINEAR = 2'd2;

  localparam logic signed [NOISE_W-1:0] PT_X [ROM_CURVES][ROM_LIMIT] = '{
    '{-16'sd16384, -16'sd13107, -16'sd6554, -16'sd1638, 16'sd1638, 16'sd4915,
      16'sd9830, 16'sd13107, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
      16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{-16'sd16384, -16'sd11469, -16'sd10650, -16'sd3277, 16'sd0, 16'sd4915,
      16'sd5734, 16'sd6881, 16'sd7373, 16'sd8192, 16'sd16384, 16'sd0,
      16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{-16'sd16384, -16'sd13107, -16'sd11469, -16'sd3277, 16'sd1638, 16'sd4915,
      16'sd5734, 16'sd6554, 16'sd9830, 16'sd14746, 16'sd16384, 16'sd0,
      16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
      16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}
  };

  localparam logic signed [VALUE_W-1:0] PT_Y [ROM_CURVES][ROM_LIMIT] = '{
    '{17'sd5120, 17'sd0, 17'sd1280, 17'sd12800, 17'sd14080, 17'sd20480,
      17'sd30720, 17'sd33280, 17'sd35840, 17'sd0, 17'sd0, 17'sd0,
      17'sd0, 17'sd0, 17'sd0, 17'sd0},
    '{17'sd435, 17'sd397, 17'sd410, 17'sd256, 17'sd102, 17'sd51,
      17'sd102, 17'sd102, 17'sd51, 17'sd26, 17'sd26, 17'sd0,
      17'sd0, 17'sd0, 17'sd0, 17'sd0},
    '{-17'sd20480, -17'sd12800, -17'sd8960, -17'sd7680, 17'sd6400, 17'sd10240,
      17'sd10240, 17'sd8960, 17'sd16640, 17'sd19200, 17'sd20480, 17'sd0,
      17'sd0, 17'sd0, 17'sd0, 17'sd0},
    '{17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0,
      17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0, 17'sd0}
  };

  localparam logic [COUNT_W-1:0] PT_COUNT [ROM_CURVES] = '{5'd9, 5'd11, 5'd11, 5'd0};

  // sideband that travels with an item through the divider and easing stages
  typedef struct packed {
    logic                      dir;
    logic signed [VALUE_W-1:0] val;
    logic signed [VALUE_W-1:0] y0;
    logic signed [VALUE_W-1:0] y1;
    logic [SEL_W-1:0]          curve;
  } side_t;

endpackage

`default_nettype wire

FILE: design/epce_if.sv
// interfaces: input item channel and result item channel
`default_nettype none

interface epce_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [epce_pkg::NOISE_W-1:0]      noise_value;
  logic [epce_pkg::SEL_W-1:0]               curve_select;

  modport source (output valid, output noise_value, output curve_select, input ready);
  modport sink (input valid, input noise_value, input curve_select, output ready);
endinterface

interface epce_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [epce_pkg::VALUE_W-1:0]      curve_value;

  modport source (output valid, output curve_value, input ready);
  modport sink (input valid, input curve_value, output ready);
endinterface

`default_nettype wire

FILE: design/epce_div.sv
// pipelined restoring divider: segment fraction t = (num << 16) / den, num < den
`default_nettype none

module epce_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [epce_pkg::T_W-1:0]    in_num,
  input  wire logic [epce_pkg::T_W-1:0]    in_den,
  input  wire epce_pkg::side_t             in_side,
  output logic                             out_valid,
  output logic [epce_pkg::T_W-1:0]         out_quot,
  output epce_pkg::side_t                  out_side
);

  localparam int NS = epce_pkg::DIV_STAGES;
  localparam int W = epce_pkg::T_W;

  logic [NS-1:0]   v_r;
  logic [NS-1:0]   v_nxt;
  logic [W-1:0]    rem_r [NS];
  logic [W-1:0]    rem_nxt [NS];
  logic [W-1:0]    quot_r [NS];
  logic [W-1:0]    quot_nxt [NS];
  logic [W-1:0]    den_r [NS];
  logic [W-1:0]    den_nxt [NS];
  epce_pkg::side_t side_r [NS];
  epce_pkg::side_t side_nxt [NS];

  always_comb begin
    logic [W:0]   trial;
    logic [W-1:0] rem;
    logic [W-1:0] quot;
    logic [W-1:0] den;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        rem = in_num;
        quot = '0;
        den = in_den;
        v_nxt[k] = in_valid;
        side_nxt[k] = in_side;
      end else begin
        rem = rem_r[k-1];
        quot = quot_r[k-1];
        den = den_r[k-1];
        v_nxt[k] = v_r[k-1];
        side_nxt[k] = side_r[k-1];
      end
      for (int b = 0; b < epce_pkg::DIV_STEP; b++) begin
        trial = {rem, 1'b0};
        if (trial >= {1'b0, den}) begin
          trial = trial - {1'b0, den};
          quot = {quot[W-2:0], 1'b1};
        end else begin
          quot = {quot[W-2:0], 1'b0};
        end
        rem = trial[W-1:0];
      end
      rem_nxt[k] = rem;
      quot_nxt[k] = quot;
      den_nxt[k] = den;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      quot_r <= quot_nxt;
      den_r <= den_nxt;
      side_r <= side_nxt;
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_quot = quot_r[NS-1];
  assign out_side = side_r[NS-1];

endmodule

`default_nettype wire

FILE: design/epce_ease.sv
// easing pipeline: smootherstep, smoothstep or linear on t, four register stages
`default_nettype none

module epce_ease (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [epce_pkg::T_W-1:0]    in_t,
  input  wire epce_pkg::side_t             in_side,
  output logic                             out_valid,
  output logic [epce_pkg::S_W-1:0]         out_s,
  output epce_pkg::side_t                  out_side
);

  localparam logic signed [20:0] FIFTEEN_Q16 = 21'sd983040;
  localparam logic signed [38:0] TEN_Q32 = 39'sd42949672960;

  // stage 1: t^2 and t*(6t - 15)
  logic                   e1_v_r;
  logic [15:0]            e1_t_r;
  logic [31:0]            e1_t2_r;
  logic signed [37:0]     e1_u_r;
  epce_pkg::side_t        e1_side_r;
  logic [31:0]            e1_t2_nxt;
  logic signed [37:0]     e1_u_nxt;
  logic [18:0]            six_t;
  logic signed [20:0]     lin_a;

  // stage 2: t^3 and smootherstep polynomial
  logic                   e2_v_r;
  logic [15:0]            e2_t_r;
  logic [31:0]            e2_t2_r;
  logic [47:0]            e2_t3_r;
  logic [19:0]            e2_p_r;
  epce_pkg::side_t        e2_side_r;
  logic [47:0]            e2_t3_nxt;
  logic [38:0]            inner;

  // stage 3: smootherstep product, smoothstep or linear value
  logic                   e3_v_r;
  logic [51:0]            e3_prod_r;
  logic [16:0]            e3_alt_r;
  epce_pkg::side_t        e3_side_r;
  logic [51:0]            e3_prod_nxt;
  logic [16:0]            e3_alt_nxt;
  logic [50:0]            ss_diff;

  // stage 4: output
  logic                   e4_v_r;
  logic [16:0]            e4_s_r;
  epce_pkg::side_t        e4_side_r;
  logic [16:0]            e4_s_nxt;

  always_comb begin
    six_t = {1'b0, in_t, 2'b00} + {2'b00, in_t, 1'b0};
    lin_a = $signed({2'b00, six_t}) - FIFTEEN_Q16;
    e1_t2_nxt = {16'b0, in_t} * {16'b0, in_t};
    e1_u_nxt = $signed({22'b0, in_t}) * $signed({{17{lin_a[20]}}, lin_a});
  end

  always_comb begin
    e2_t3_nxt = {16'b0, e1_t2_r} * {32'b0, e1_t_r};
    inner = 39'({e1_u_r[37], e1_u_r} + TEN_Q32);
  end

  always_comb begin
    e3_prod_nxt = {20'b0, e2_t3_r[47:16]} * {32'b0, e2_p_r};
    ss_diff = {3'b000, e2_t2_r, 16'b0} + {2'b00, e2_t2_r, 17'b0}
            - {2'b00, e2_t3_r, 1'b0};
    case (e2_side_r.curve)
      epce_pkg::CURVE_SMOOTH: e3_alt_nxt = ss_diff[48:32];
      default:                e3_alt_nxt = {1'b0, e2_t_r};
    endcase
  end

  always_comb begin
    case (e3_side_r.curve)
      epce_pkg::CURVE_SMOOTHER: e4_s_nxt = e3_prod_r[48:32];
      default:                  e4_s_nxt = e3_alt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
      e3_v_r <= 1'b0;
      e4_v_r <= 1'b0;
    end else if (en) begin
      e1_v_r <= in_valid;
      e2_v_r <= e1_v_r;
      e3_v_r <= e2_v_r;
      e4_v_r <= e3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_t_r <= in_t;
      e1_t2_r <= e1_t2_nxt;
      e1_u_r <= e1_u_nxt;
      e1_side_r <= in_side;
      e2_t_r <= e1_t_r;
      e2_t2_r <= e1_t2_r;
      e2_t3_r <= e2_t3_nxt;
      e2_p_r <= inner[35:16];
      e2_side_r <= e1_side_r;
      e3_prod_r <= e3_prod_nxt;
      e3_alt_r <= e3_alt_nxt;
      e3_side_r <= e2_side_r;
      e4_s_r <= e4_s_nxt;
      e4_side_r <= e3_side_r;
    end
  end

  assign out_valid = e4_v_r;
  assign out_s = e4_s_r;
  assign out_side = e4_side_r;

endmodule

`default_nettype wire

FILE: design/eased_piecewise_curve_eval_core.sv
// top level: eased piecewise breakpoint curve evaluator
//
//   channel   dir   handshake      payload
//   in_chan   in    valid/ready    noise_value (s16 Q2.14), curve_select (u2)
//   out_chan  out   valid/ready    curve_value (s17 Q9.8)
//
// one item per cycle while out_chan is not stalled, 16 register stages
// the pipeline includes the 8-stage segment divider and 4-stage easing multipliers
// every stage advances together whenever the output register is empty or taken
// a stall on out_chan holds the whole pipeline and drops in_chan.ready
// synchronous active-low reset clears the valid bits only
`default_nettype none

module eased_piecewise_curve_eval_core #(
  parameter int MAX_POINTS = epce_pkg::MAX_POINTS_DEF,
  parameter int NUM_CURVES = epce_pkg::NUM_CURVES_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  epce_in_if.sink      in_chan,
  epce_out_if.source   out_chan
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CW = epce_pkg::COUNT_W;
  localparam int VW = epce_pkg::VALUE_W;

  logic adv;

  // stage 1: range check and segment search
  logic                        s1_v_r;
  logic                        s1_dir_r;
  logic signed [VW-1:0]        s1_val_r;
  logic signed [15:0]          s1_n_r;
  logic [1:0]                  s1_c_r;
  logic [IDX_W-1:0]            s1_idx_r;
  logic                        s1_dir_nxt;
  logic signed [VW-1:0]        s1_val_nxt;
  logic [IDX_W-1:0]            s1_idx_nxt;

  // stage 2: segment fetch
  logic                        s2_v_r;
  logic [15:0]                 s2_num_r;
  logic [15:0]                 s2_den_r;
  epce_pkg::side_t             s2_side_r;
  logic [15:0]                 s2_num_nxt;
  logic [15:0]                 s2_den_nxt;
  epce_pkg::side_t             s2_side_nxt;

  logic                        div_v;
  logic [15:0]                 div_t;
  epce_pkg::side_t             div_side;

  logic                        ease_v;
  logic [16:0]                 ease_s;
  epce_pkg::side_t             ease_side;

  // interpolation
  logic                        i1_v_r;
  logic signed [35:0]          i1_m_r;
  epce_pkg::side_t             i1_side_r;
  logic signed [17:0]          dy;
  logic signed [35:0]          i1_m_nxt;

  logic                        out_valid_r;
  logic signed [VW-1:0]        out_value_r;
  logic signed [VW-1:0]        out_value_nxt;
  logic signed [20:0]          sum;
  logic signed [VW-1:0]        lo;
  logic signed [VW-1:0]        hi;

  assign adv = !out_valid_r || out_chan.ready;
  assign in_chan.ready = adv;

  always_comb begin
    logic [1:0]        c;
    logic [CW-1:0]     len;
    logic [CW-1:0]     last;
    logic              ok;
    logic signed [15:0] n;
    c = in_chan.curve_select;
    n = in_chan.noise_value;
    len = epce_pkg::PT_COUNT[c];
    if (len > CW'(MAX_POINTS)) begin
      len = CW'(MAX_POINTS);
    end
    last = len - 1'b1;
    ok = (3'(c) < 3'(NUM_CURVES)) && (len != '0);
    s1_idx_nxt = IDX_W'(MAX_POINTS - 1);
    for (int j = MAX_POINTS - 1; j >= 1; j--) begin
      if ((CW'(j) <= last) && (n <= epce_pkg::PT_X[c][epce_pkg::ROM_IDX_W'(j)])) begin
        s1_idx_nxt = IDX_W'(j);
      end
    end
    if (!ok) begin
      s1_dir_nxt = 1'b1;
      s1_val_nxt = '0;
    end else if (n <= epce_pkg::PT_X[c][0]) begin
      s1_dir_nxt = 1'b1;
      s1_val_nxt = epce_pkg::PT_Y[c][0];
    end else if (n >= epce_pkg::PT_X[c][last[epce_pkg::ROM_IDX_W-1:0]]) begin
      s1_dir_nxt = 1'b1;
      s1_val_nxt = epce_pkg::PT_Y[c][last[epce_pkg::ROM_IDX_W-1:0]];
    end else begin
      s1_dir_nxt = 1'b0;
      s1_val_nxt = '0;
    end
  end

  always_comb begin
    logic [epce_pkg::ROM_IDX_W-1:0] i1;
    logic [epce_pkg::ROM_IDX_W-1:0] i0;
    logic signed [15:0]             x0;
    logic signed [15:0]             x1;
    logic signed [16:0]             dx;
    logic signed [16:0]             dn;
    i1 = epce_pkg::ROM_IDX_W'(s1_idx_r);
    i0 = i1 - 1'b1;
    x0 = epce_pkg::PT_X[s1_c_r][i0];
    x1 = epce_pkg::PT_X[s1_c_r][i1];
    dx = {x1[15], x1} - {x0[15], x0};
    dn = {s1_n_r[15], s1_n_r} - {x0[15], x0};
    s2_num_nxt = dn[15:0];
    s2_den_nxt = dx[15:0];
    s2_side_nxt.curve = s1_c_r;
    s2_side_nxt.y0 = epce_pkg::PT_Y[s1_c_r][i0];
    s2_side_nxt.y1 = epce_pkg::PT_Y[s1_c_r][i1];
    if (s1_dir_r) begin
      s2_side_nxt.dir = 1'b1;
      s2_side_nxt.val = s1_val_r;
    end else if (s1_n_r == x1) begin
      s2_side_nxt.dir = 1'b1;
      s2_side_nxt.val = epce_pkg::PT_Y[s1_c_r][i1];
    end else if ((dx <= 17'sd0) || (s1_n_r < x0)) begin
      s2_side_nxt.dir = 1'b1;
      s2_side_nxt.val = epce_pkg::PT_Y[s1_c_r][i0];
    end else begin
      s2_side_nxt.dir = 1'b0;
      s2_side_nxt.val = '0;
    end
  end

  epce_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s2_v_r),
    .in_num    (s2_num_r),
    .in_den    (s2_den_r),
    .in_side   (s2_side_r),
    .out_valid (div_v),
    .out_quot  (div_t),
    .out_side  (div_side)
  );

  epce_ease u_ease (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (div_v),
    .in_t      (div_t),
    .in_side   (div_side),
    .out_valid (ease_v),
    .out_s     (ease_s),
    .out_side  (ease_side)
  );

  always_comb begin
    dy = {ease_side.y1[VW-1], ease_side.y1} - {ease_side.y0[VW-1], ease_side.y0};
    i1_m_nxt = $signed({19'b0, ease_s}) * $signed({{18{dy[17]}}, dy});
  end

  // direct value when dir is set, else floor of the scaled step, then clamp to the segment's height span
  always_comb begin
    sum = {{4{i1_side_r.y0[VW-1]}}, i1_side_r.y0} + {i1_m_r[35], i1_m_r[35:16]};
    if (i1_side_r.y0 < i1_side_r.y1) begin
      lo = i1_side_r.y0;
      hi = i1_side_r.y1;
    end else begin
      lo = i1_side_r.y1;
      hi = i1_side_r.y0;
    end
    if (i1_side_r.dir) begin
      out_value_nxt = i1_side_r.val;
    end else if (sum < $signed({{4{lo[VW-1]}}, lo})) begin
      out_value_nxt = lo;
    end else if (sum > $signed({{4{hi[VW-1]}}, hi})) begin
      out_value_nxt = hi;
    end else begin
      out_value_nxt = sum[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      i1_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_chan.valid;
      s2_v_r <= s1_v_r;
      i1_v_r <= ease_v;
      out_valid_r <= i1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dir_r <= s1_dir_nxt;
      s1_val_r <= s1_val_nxt;
      s1_n_r <= in_chan.noise_value;
      s1_c_r <= in_chan.curve_select;
      s1_idx_r <= s1_idx_nxt;
      s2_num_r <= s2_num_nxt;
      s2_den_r <= s2_den_nxt;
      s2_side_r <= s2_side_nxt;
      i1_m_r <= i1_m_nxt;
      i1_side_r <= ease_side;
      out_value_r <= out_value_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.curve_value = out_value_r;

endmodule

`default_nettype wire
